// ===== rtl/lz77_back_reference_resolver_assert.svh =====
// Assertion macros used by the resolver port checker.
`ifndef LZ77_BACK_REFERENCE_RESOLVER_ASSERT_SVH
`define LZ77_BACK_REFERENCE_RESOLVER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LZBR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzbr assertion failed");

// Consequent holds in the cycle after the antecedent.
`define LZBR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzbr assertion failed");

`endif

// ===== rtl/lzbr_pkg.sv =====
// Types, constants and code tables of the back-reference resolver.
package lzbr_pkg;

  localparam int WIN_DEPTH = 32768;
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int BW_W      = WIN_AW + 1;
  localparam int LANES     = 8;
  localparam int LANE_W    = $clog2(LANES);
  localparam int CNT_W     = 4;

  localparam logic [8:0] SYM_END       = 9'd256;
  localparam logic [8:0] SYM_FIRST_LEN = 9'd257;
  localparam logic [8:0] SYM_LAST_LEN  = 9'd285;
  localparam logic [4:0] DIST_LAST     = 5'd29;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_END    = 2'd1;
  localparam logic [1:0] STAT_BADSYM = 2'd2;
  localparam logic [1:0] STAT_BADREF = 2'd3;

  typedef enum logic [2:0] {TK_LIT, TK_EOB, TK_BADSYM, TK_BADREF, TK_COPY} tok_kind_t;

  typedef struct packed {
    tok_kind_t   kind;
    logic [8:0]  length;
    logic [15:0] distance;
  } tok_t;

  typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_WRITE, ST_FLUSH} state_t;

  function automatic logic [8:0] len_base(input logic [4:0] i);
    case (i)
      5'd0: len_base = 9'd3;     5'd1: len_base = 9'd4;     5'd2: len_base = 9'd5;
      5'd3: len_base = 9'd6;     5'd4: len_base = 9'd7;     5'd5: len_base = 9'd8;
      5'd6: len_base = 9'd9;     5'd7: len_base = 9'd10;    5'd8: len_base = 9'd11;
      5'd9: len_base = 9'd13;    5'd10: len_base = 9'd15;   5'd11: len_base = 9'd17;
      5'd12: len_base = 9'd19;   5'd13: len_base = 9'd23;   5'd14: len_base = 9'd27;
      5'd15: len_base = 9'd31;   5'd16: len_base = 9'd35;   5'd17: len_base = 9'd43;
      5'd18: len_base = 9'd51;   5'd19: len_base = 9'd59;   5'd20: len_base = 9'd67;
      5'd21: len_base = 9'd83;   5'd22: len_base = 9'd99;   5'd23: len_base = 9'd115;
      5'd24: len_base = 9'd131;  5'd25: len_base = 9'd163;  5'd26: len_base = 9'd195;
      5'd27: len_base = 9'd227;  5'd28: len_base = 9'd258;
      default: len_base = 9'd0;
    endcase
  endfunction

  function automatic logic [2:0] len_bits(input logic [4:0] i);
    if (i < 5'd8 || i > 5'd27) len_bits = 3'd0;
    else len_bits = 3'((i - 5'd4) >> 2);
  endfunction

  function automatic logic [15:0] dist_start(input logic [4:0] i);
    case (i)
      5'd0: dist_start = 16'd1;       5'd1: dist_start = 16'd2;
      5'd2: dist_start = 16'd3;       5'd3: dist_start = 16'd4;
      5'd4: dist_start = 16'd5;       5'd5: dist_start = 16'd7;
      5'd6: dist_start = 16'd9;       5'd7: dist_start = 16'd13;
      5'd8: dist_start = 16'd17;      5'd9: dist_start = 16'd25;
      5'd10: dist_start = 16'd33;     5'd11: dist_start = 16'd49;
      5'd12: dist_start = 16'd65;     5'd13: dist_start = 16'd97;
      5'd14: dist_start = 16'd129;    5'd15: dist_start = 16'd193;
      5'd16: dist_start = 16'd257;    5'd17: dist_start = 16'd385;
      5'd18: dist_start = 16'd513;    5'd19: dist_start = 16'd769;
      5'd20: dist_start = 16'd1025;   5'd21: dist_start = 16'd1537;
      5'd22: dist_start = 16'd2049;   5'd23: dist_start = 16'd3073;
      5'd24: dist_start = 16'd4097;   5'd25: dist_start = 16'd6145;
      5'd26: dist_start = 16'd8193;   5'd27: dist_start = 16'd12289;
      5'd28: dist_start = 16'd16385;  5'd29: dist_start = 16'd24577;
      default: dist_start = 16'd0;
    endcase
  endfunction

  function automatic logic [3:0] dist_bits(input logic [4:0] i);
    if (i < 5'd4 || i > 5'd29) dist_bits = 4'd0;
    else dist_bits = 4'((i - 5'd2) >> 1);
  endfunction

endpackage

// ===== rtl/lzbr_window_ram.sv =====
// History window memory, one write and one registered read port.
module lzbr_window_ram
  import lzbr_pkg::*;
(
  input  logic              clk,
  input  logic              we,
  input  logic [WIN_AW-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic [WIN_AW-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [WIN_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lzbr_token_decode.sv =====
// Token classification and length/distance table lookup.
module lzbr_token_decode
  import lzbr_pkg::*;
(
  input  logic [8:0]      sym,
  input  logic [4:0]      lext,
  input  logic [4:0]      dsym,
  input  logic [12:0]     dext,
  input  logic [BW_W-1:0] written,
  output tok_t            tok
);

  logic [4:0]  li;
  logic [2:0]  lbits;
  logic [3:0]  dbits;
  logic [4:0]  lmask;
  logic [12:0] dmask;

  always_comb begin
    li    = 5'(sym - SYM_FIRST_LEN);
    lbits = len_bits(li);
    dbits = dist_bits(dsym);
    lmask = 5'((6'd1 << lbits) - 6'd1);
    dmask = 13'((14'd1 << dbits) - 14'd1);
    tok.length   = len_base(li) + 9'(lext & lmask);
    tok.distance = dist_start(dsym) + 16'(dext & dmask);
    if (sym < SYM_END) begin
      tok.kind = TK_LIT;
    end else if (sym == SYM_END) begin
      tok.kind = TK_EOB;
    end else if (sym > SYM_LAST_LEN || dsym > DIST_LAST) begin
      tok.kind = TK_BADSYM;
    end else if (BW_W'(tok.distance) > written) begin
      tok.kind = TK_BADREF;
    end else begin
      tok.kind = TK_COPY;
    end
  end

endmodule

// ===== rtl/lz77_back_reference_resolver.sv =====
// Top level: DEFLATE back-reference resolver over a 32 KiB history window.
// A literal or status token reaches the output register in the cycle after accept.
// Tokens are taken only in idle, when the output register is empty or after an error.
// A copy is accepted, then each byte takes one window read and one write-back, with a
// flush wait whenever the output is full. Reset: synchronous, clears the write pointer,
// byte count, error flag and handshake state; window stays undefined until written.
module lz77_back_reference_resolver
  import lzbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // length_symbol, length_extra, distance_symbol, distance_extra
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // byte0 .. byte7, valid_count, zero pad
  output logic [71:0] m_tdata,
  output logic        m_tlast,
  // status
  output logic [1:0]  m_tuser
);

  state_t            state, state_next;
  tok_t              tok;
  logic [WIN_AW-1:0] wp, src;
  logic [BW_W-1:0]   written;
  logic              err;
  logic [8:0]        remain;
  logic [CNT_W-1:0]  lane;
  logic [7:0]        acc [LANES];
  logic [7:0]        acc_ins [LANES];
  logic [7:0]        obyte [LANES];
  logic [CNT_W-1:0]  ocnt;
  logic              ovalid, olast;
  logic [1:0]        ostat;
  logic              accept, emit, ram_we;
  logic [7:0]        ram_wdata, ram_rdata;

  lzbr_token_decode u_dec (
    .sym     (s_tdata[8:0]),
    .lext    (s_tdata[13:9]),
    .dsym    (s_tdata[18:14]),
    .dext    (s_tdata[31:19]),
    .written (written),
    .tok     (tok)
  );

  lzbr_window_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (ram_wdata),
    .raddr (src),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    emit       = (lane == CNT_W'(LANES - 1)) || (remain == 9'd1);
    case (state)
      ST_IDLE: begin
        s_tready = err || !ovalid;
        if (s_tvalid && s_tready && !err && tok.kind == TK_COPY) state_next = ST_READ;
      end
      ST_READ: state_next = ST_WRITE;
      ST_WRITE: begin
        if (!emit) state_next = ST_READ;
        else if (ovalid) state_next = ST_FLUSH;
        else state_next = (remain == 9'd1) ? ST_IDLE : ST_READ;
      end
      ST_FLUSH: begin
        if (!ovalid) state_next = (remain == 9'd0) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
    accept    = s_tvalid && s_tready;
    ram_we    = (state == ST_WRITE) || (accept && !err && tok.kind == TK_LIT);
    ram_wdata = (state == ST_WRITE) ? ram_rdata : s_tdata[7:0];
    for (int i = 0; i < LANES; i++) begin
      acc_ins[i] = (lane[LANE_W-1:0] == LANE_W'(i)) ? ram_rdata : acc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      wp      <= '0;
      written <= '0;
      err     <= 1'b0;
      ovalid  <= 1'b0;
      lane    <= '0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) ovalid <= 1'b0;
      if (ram_we) begin
        wp <= wp + 1'b1;
        if (written != BW_W'(WIN_DEPTH)) written <= written + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept && !err) begin
            obyte[0] <= (tok.kind == TK_LIT) ? s_tdata[7:0] : 8'd0;
            for (int i = 1; i < LANES; i++) begin
              obyte[i] <= '0;
            end
            ocnt   <= (tok.kind == TK_LIT) ? CNT_W'(1) : '0;
            olast  <= 1'b1;
            ovalid <= tok.kind != TK_COPY;
            case (tok.kind)
              TK_LIT: ostat <= STAT_OK;
              TK_EOB: ostat <= STAT_END;
              TK_BADSYM: begin
                ostat <= STAT_BADSYM;
                err   <= 1'b1;
              end
              TK_BADREF: begin
                ostat <= STAT_BADREF;
                err   <= 1'b1;
              end
              default: begin
                src    <= wp - WIN_AW'(tok.distance);
                remain <= tok.length;
                lane   <= '0;
                acc    <= '{default: '0};
              end
            endcase
          end
        end
        ST_WRITE: begin
          src    <= src + 1'b1;
          remain <= remain - 9'd1;
          if (emit && !ovalid) begin
            obyte  <= acc_ins;
            ocnt   <= lane + 1'b1;
            olast  <= remain == 9'd1;
            ostat  <= STAT_OK;
            ovalid <= 1'b1;
            lane   <= '0;
            acc    <= '{default: '0};
          end else begin
            acc  <= acc_ins;
            lane <= lane + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (!ovalid) begin
            obyte  <= acc;
            ocnt   <= lane;
            olast  <= remain == 9'd0;
            ostat  <= STAT_OK;
            ovalid <= 1'b1;
            lane   <= '0;
            acc    <= '{default: '0};
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < LANES; i++) begin
      m_tdata[8*i +: 8] = obyte[i];
    end
    m_tdata[8*LANES +: CNT_W] = ocnt;
  end

  assign m_tvalid = ovalid;
  assign m_tlast  = olast;
  assign m_tuser  = ostat;

endmodule

// ===== rtl/lzbr_checker.sv =====
// Port checker for the resolver, bound to the top level.
`include "lz77_back_reference_resolver_assert.svh"

module lzbr_checker
  import lzbr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast,
  input logic [1:0]  m_tuser
);

  `LZBR_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `LZBR_ASSERT_NOW(a_cnt_range, m_tvalid, m_tdata[67:64] <= 4'd8)
  `LZBR_ASSERT_NOW(a_stat_single, m_tvalid && m_tuser != STAT_OK,
                   m_tlast && m_tdata[67:64] == 4'd0)
  `LZBR_ASSERT_NOW(a_full_mid, m_tvalid && !m_tlast, m_tdata[67:64] == 4'd8)

endmodule

bind lz77_back_reference_resolver lzbr_checker u_lzbr_checker (.*);
